[hdl/scale_weight_frame_parser_unit_defines.svh]
// Assertion macros used by the checker file of the weight frame parser.
`ifndef SCALE_WEIGHT_FRAME_PARSER_UNIT_DEFINES_SVH
`define SCALE_WEIGHT_FRAME_PARSER_UNIT_DEFINES_SVH

// Same-cycle implication, sampled on i_clk and disabled while i_rst_n is low.
`define SWFP_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("swfp check failed");

// Next-cycle implication, sampled on i_clk and disabled while i_rst_n is low.
`define SWFP_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("swfp check failed");

`endif

[hdl/swfp_pkg.sv]
// Types, constants and helper functions of the weight frame parser.
package swfp_pkg;

    localparam int MAX_DIGITS_DEF       = 12;
    localparam int MAX_UNIT_LETTERS_DEF = 3;
    localparam int DCNT_W               = 5;
    localparam int MANT_W               = 40;

    localparam logic [7:0] CH_S     = 8'h53;
    localparam logic [7:0] CH_C     = 8'h43;
    localparam logic [7:0] CH_U     = 8'h55;
    localparam logic [7:0] CH_I     = 8'h49;
    localparam logic [7:0] CH_ONE   = 8'h31;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_QUEST = 8'h3F;
    localparam logic [7:0] CH_CARET = 8'h5E;
    localparam logic [7:0] CH_LOW_V = 8'h76;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_POINT = 8'h2E;
    localparam logic [7:0] CH_COMMA = 8'h2C;
    localparam logic [7:0] CH_LBR   = 8'h5B;
    localparam logic [7:0] CH_RBR   = 8'h5D;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_G     = 8'h67;
    localparam logic [7:0] CH_K     = 8'h6B;
    localparam logic [7:0] CH_LOW_C = 8'h63;
    localparam logic [7:0] CH_T     = 8'h74;
    localparam logic [7:0] CH_L     = 8'h6C;
    localparam logic [7:0] CH_B     = 8'h62;
    localparam logic [7:0] CH_O     = 8'h6F;
    localparam logic [7:0] CH_Z     = 8'h7A;
    localparam logic [7:0] CASE_BIT = 8'h20;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_NO_DIGITS = 2'd1,
        ST_TWO_POINT = 2'd2,
        ST_TOO_MANY  = 2'd3
    } t_status;

    typedef enum logic [2:0] {
        UNIT_NONE = 3'd0,
        UNIT_G    = 3'd1,
        UNIT_KG   = 3'd2,
        UNIT_CT   = 3'd3,
        UNIT_LB   = 3'd4,
        UNIT_OZ   = 3'd5
    } t_unit;

    typedef enum logic [15:0] {
        PH_START = 16'h0001,
        PH_S     = 16'h0002,
        PH_SU    = 16'h0004,
        PH_C     = 16'h0008,
        PH_C2    = 16'h0010,
        PH_SP1   = 16'h0020,
        PH_STAB  = 16'h0040,
        PH_SP2   = 16'h0080,
        PH_SIGN  = 16'h0100,
        PH_WS    = 16'h0200,
        PH_NUM   = 16'h0400,
        PH_BR1   = 16'h0800,
        PH_BR2   = 16'h1000,
        PH_WS2   = 16'h2000,
        PH_UNIT  = 16'h4000,
        PH_DONE  = 16'h8000
    } t_phase;

    typedef struct packed {
        logic [7:0] frame_byte;
        logic       last_byte;
    } t_in_item;

    typedef struct packed {
        t_status           status;
        logic              negative;
        logic [MANT_W-1:0] mantissa;
        logic [3:0]        fraction_digits;
        logic              stable;
        t_unit             unit_code;
    } t_out_item;

    typedef struct packed {
        t_phase            phase;
        logic [MANT_W-1:0] value;
        logic [DCNT_W-1:0] dcnt;
        logic [3:0]        apc;
        logic              point_seen;
        logic              negative;
        logic              stable;
        t_status           err;
        logic [7:0]        letter0;
        logic [7:0]        letter1;
        logic [1:0]        lcnt;
    } t_pstate;

    function automatic t_pstate pstate_reset();
        t_pstate s;
        s            = '0;
        s.phase      = PH_START;
        s.stable     = 1'b1;
        s.err        = ST_OK;
        return s;
    endfunction

    function automatic logic is_digit(logic [7:0] b);
        return (b >= CH_ZERO) && (b <= CH_NINE);
    endfunction

    function automatic logic is_blank(logic [7:0] b);
        return (b == CH_SPACE) || (b == CH_TAB);
    endfunction

    function automatic logic is_letter(logic [7:0] b);
        return ((b | CASE_BIT) >= 8'h61) && ((b | CASE_BIT) <= CH_Z);
    endfunction

    function automatic logic is_mark(logic [7:0] b);
        return (b == CH_QUEST) || (b == CH_CARET) || (b == CH_LOW_V);
    endfunction

endpackage

[hdl/scale_weight_frame_parser_unit.sv]
// Top level of the ASCII weight frame parser.
// The result of a frame is registered and appears in the cycle after its last byte is accepted.
// Throughput: one byte per cycle; the single parse step between the state
// registers and the result register sets the rate.
// A result held under stall blocks further bytes until it is taken.
// Synchronous active-low reset returns the parser to the frame start and empties the output.
module scale_weight_frame_parser_unit
    import swfp_pkg::*;
#(
    parameter int MAX_DIGITS       = MAX_DIGITS_DEF,
    parameter int MAX_UNIT_LETTERS = MAX_UNIT_LETTERS_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_stall,
    input  t_in_item  i_in_item,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_item o_out_item
);

    t_pstate   r_state;
    t_pstate   n_state;
    t_pstate   step_nxt;
    t_out_item step_res;
    logic      r_out_valid;
    logic      n_out_valid;
    t_out_item r_out;
    logic      accept;

    swfp_step #(
        .MAX_DIGITS       (MAX_DIGITS),
        .MAX_UNIT_LETTERS (MAX_UNIT_LETTERS)
    ) u_step (
        .i_cur  (r_state),
        .i_item (i_in_item),
        .o_nxt  (step_nxt),
        .o_res  (step_res)
    );

    assign o_in_stall = r_out_valid && i_out_stall;
    assign accept     = i_in_valid && !o_in_stall;

    always_comb begin
        n_state     = r_state;
        n_out_valid = r_out_valid && i_out_stall;
        if (accept) begin
            if (i_in_item.last_byte) begin
                n_state     = pstate_reset();
                n_out_valid = 1'b1;
            end else begin
                n_state = step_nxt;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= pstate_reset();
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept && i_in_item.last_byte) begin
            r_out <= step_res;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

endmodule

[hdl/swfp_step.sv]
// Next-state and result logic for one frame byte of the weight frame parser.
module swfp_step
    import swfp_pkg::*;
#(
    parameter int MAX_DIGITS       = MAX_DIGITS_DEF,
    parameter int MAX_UNIT_LETTERS = MAX_UNIT_LETTERS_DEF
) (
    input  t_pstate   i_cur,
    input  t_in_item  i_item,
    output t_pstate   o_nxt,
    output t_out_item o_res
);

    // Skips the phases that let this byte fall through and returns the one that takes it.
    function automatic t_phase absorb_phase(t_phase ph, logic [7:0] b, logic no_digits);
        t_phase p;
        p = ph;
        for (int k = 0; k < 8; k++) begin
            case (p)
                PH_START: if (!(b == CH_S || b == CH_C)) p = PH_SP1;
                PH_S:     if (!(b == CH_U || b == CH_I)) p = PH_SP1;
                PH_SU:    if (b != CH_I) p = PH_SP1;
                PH_C2:    if (b != CH_ONE) p = PH_SP1;
                PH_SP1:   if (b != CH_SPACE) p = PH_STAB;
                PH_STAB:  if (!(is_mark(b) || b == CH_SPACE)) p = PH_SP2;
                PH_SP2:   if (b != CH_SPACE) p = PH_SIGN;
                PH_SIGN:  if (!(b == CH_MINUS || b == CH_PLUS || b == CH_SPACE)) p = PH_WS;
                PH_WS:    if (!is_blank(b)) p = PH_NUM;
                PH_NUM: begin
                    if (!(is_digit(b) || b == CH_POINT || b == CH_COMMA || no_digits
                          || b == CH_LBR)) p = PH_WS2;
                end
                PH_BR1:   if (!is_digit(b)) p = PH_BR2;
                PH_BR2:   if (b != CH_RBR) p = PH_WS2;
                PH_WS2:   if (!is_blank(b)) p = PH_UNIT;
                default:  p = p;
            endcase
        end
        return p;
    endfunction

    logic [7:0]        b;
    t_phase            ph_abs;
    logic              dig_room;
    logic [MANT_W-1:0] value_add;
    t_pstate           n;
    t_status           status;
    t_unit             unit;

    assign b        = i_item.frame_byte;
    assign ph_abs   = absorb_phase(i_cur.phase, b, i_cur.dcnt == '0);
    assign dig_room = i_cur.dcnt < DCNT_W'(MAX_DIGITS);
    assign value_add = {i_cur.value[MANT_W-4:0], 3'b000} + {i_cur.value[MANT_W-2:0], 1'b0}
                     + {{(MANT_W-4){1'b0}}, b[3:0]};

    always_comb begin
        logic take_digit;
        n          = i_cur;
        n.phase    = ph_abs;
        take_digit = 1'b0;
        case (ph_abs)
            PH_START: n.phase = (b == CH_S) ? PH_S : PH_C;
            PH_S:     n.phase = (b == CH_U) ? PH_SU : PH_SP1;
            PH_SU:    n.phase = PH_SP1;
            PH_C:     n.phase = (b == CH_ONE || b == CH_U) ? PH_C2 : PH_DONE;
            PH_C2:    n.phase = PH_SP1;
            PH_SP1:   n.phase = PH_STAB;
            PH_STAB: begin
                n.stable = !is_mark(b);
                n.phase  = PH_SP2;
            end
            PH_SP2:   n.phase = PH_SIGN;
            PH_SIGN: begin
                if (b == CH_MINUS) n.negative = 1'b1;
                n.phase = PH_WS;
            end
            PH_WS:    n.phase = PH_WS;
            PH_NUM: begin
                if (is_digit(b)) begin
                    take_digit = 1'b1;
                end else if (b == CH_POINT || b == CH_COMMA) begin
                    if (i_cur.point_seen) n.err = ST_TWO_POINT;
                    else n.point_seen = 1'b1;
                end else if (i_cur.dcnt == '0) begin
                    n.phase = PH_DONE;
                end else begin
                    n.phase = PH_BR1;
                end
            end
            PH_BR1: begin
                take_digit = 1'b1;
                n.phase    = PH_BR2;
            end
            PH_BR2:   n.phase = PH_WS2;
            PH_WS2:   n.phase = PH_WS2;
            PH_UNIT: begin
                if (is_letter(b) && (i_cur.lcnt < 2'(MAX_UNIT_LETTERS))) begin
                    if (i_cur.lcnt == 2'd0) n.letter0 = b | CASE_BIT;
                    if (i_cur.lcnt == 2'd1) n.letter1 = b | CASE_BIT;
                    n.lcnt = i_cur.lcnt + 2'd1;
                end else begin
                    n.phase = PH_DONE;
                end
            end
            default:  n.phase = PH_DONE;
        endcase
        if (take_digit) begin
            if (dig_room) begin
                n.value = value_add;
                n.dcnt  = i_cur.dcnt + DCNT_W'(1);
                if (i_cur.point_seen && i_cur.apc != 4'd15) n.apc = i_cur.apc + 4'd1;
            end else if (i_cur.err == ST_OK) begin
                n.err = ST_TOO_MANY;
            end
        end
    end

    always_comb begin
        unit = UNIT_NONE;
        if (n.lcnt == 2'd1 && n.letter0 == CH_G) unit = UNIT_G;
        if (n.lcnt == 2'd2) begin
            if (n.letter0 == CH_K && n.letter1 == CH_G) unit = UNIT_KG;
            if (n.letter0 == CH_LOW_C && n.letter1 == CH_T) unit = UNIT_CT;
            if (n.letter0 == CH_L && n.letter1 == CH_B) unit = UNIT_LB;
            if (n.letter0 == CH_O && n.letter1 == CH_Z) unit = UNIT_OZ;
        end
    end

    assign status = (n.dcnt == '0) ? ST_NO_DIGITS : n.err;

    always_comb begin
        o_res        = '0;
        o_res.status = status;
        o_res.stable = n.stable;
        if (status == ST_OK) begin
            o_res.negative        = n.negative;
            o_res.mantissa        = n.value;
            o_res.fraction_digits = n.apc;
            o_res.unit_code       = unit;
        end else begin
            o_res.unit_code       = UNIT_NONE;
        end
    end

    assign o_nxt = n;

endmodule

[hdl/swfp_checker.sv]
// Port-level checker for the weight frame parser and its bind.
`include "scale_weight_frame_parser_unit_defines.svh"

module swfp_checker
    import swfp_pkg::*;
(
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      i_in_valid,
    input logic      o_in_stall,
    input t_in_item  i_in_item,
    input logic      o_out_valid,
    input logic      i_out_stall,
    input t_out_item o_out_item
);

    `SWFP_ASSERT_NXT(a_out_hold, o_out_valid && i_out_stall, o_out_valid && $stable(o_out_item))
    `SWFP_ASSERT_IMP(a_err_zero, o_out_valid && o_out_item.status != ST_OK, o_out_item.mantissa == '0 && !o_out_item.negative && o_out_item.fraction_digits == 4'd0 && o_out_item.unit_code == UNIT_NONE)
    `SWFP_ASSERT_IMP(a_rise_last, $rose(o_out_valid), $past(i_in_valid && !o_in_stall && i_in_item.last_byte))
    `SWFP_ASSERT_NXT(a_no_phantom, i_in_valid && !o_in_stall && !i_in_item.last_byte && !o_out_valid, !o_out_valid)

endmodule

bind scale_weight_frame_parser_unit swfp_checker u_swfp_checker (.*);

[tb/sv/tb_top.sv]
// Self-checking testbench of the weight frame parser: directed frames, then random frames.
`timescale 1ns / 1ps

module tb_top;
    import swfp_pkg::*;

    localparam int QUIET_LIMIT = 3000;
    localparam int HOLD_CYCLES = 300;
    localparam int BYTE_BUDGET = 1850;

    logic      i_clk;
    logic      rst_n = 1'b0;
    logic      in_valid = 1'b0;
    logic      in_stall;
    t_in_item  in_item = '0;
    logic      out_valid;
    logic      out_stall = 1'b0;
    t_out_item out_item;

    scale_weight_frame_parser_unit dut (
        .i_clk       (i_clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_item   (in_item),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_item  (out_item)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    t_out_item pending_weights[$];
    int        bad_results = 0;
    bit        send_idle = 1'b0;
    bit        recv_idle = 1'b0;
    int        hold_requests = 0;

    string     row_text[$];
    bit        row_typed[$];
    t_out_item row_result[$];

    t_phase            fp_phase;
    logic [MANT_W-1:0] fp_value;
    int                fp_digits;
    int                fp_frac;
    int                fp_letters_n;
    bit                fp_point;
    bit                fp_neg;
    bit                fp_stable;
    t_status           fp_err;
    logic [7:0]        fp_letter [3];

    function automatic bit numeral(input logic [7:0] b);
        return b >= "0" && b <= "9";
    endfunction

    function automatic bit blank_char(input logic [7:0] b);
        return b == " " || b == "\t";
    endfunction

    function automatic void clear_parse();
        fp_phase     = PH_START;
        fp_value     = '0;
        fp_digits    = 0;
        fp_frac      = 0;
        fp_letters_n = 0;
        fp_point     = 1'b0;
        fp_neg       = 1'b0;
        fp_stable    = 1'b1;
        fp_err       = ST_OK;
        for (int i = 0; i < 3; i++) fp_letter[i] = '0;
    endfunction

    function automatic void take_digit(input logic [7:0] b);
        if (fp_digits < MAX_DIGITS_DEF) begin
            fp_value = fp_value * 10 + MANT_W'(b - "0");
            fp_digits++;
            if (fp_point && fp_frac < 15) fp_frac++;
        end else if (fp_err == ST_OK) begin
            fp_err = ST_TOO_MANY;
        end
    endfunction

    // A byte that does not fit the current field is handed on to the next field.
    function automatic void scan_byte(input logic [7:0] b);
        bit taken;
        taken = 1'b0;
        for (int k = 0; k < 20 && !taken; k++) begin
            taken = 1'b1;
            case (fp_phase)
                PH_START: begin
                    if (b == "S") fp_phase = PH_S;
                    else if (b == "C") fp_phase = PH_C;
                    else begin fp_phase = PH_SP1; taken = 1'b0; end
                end
                PH_S: begin
                    if (b == "U") fp_phase = PH_SU;
                    else if (b == "I") fp_phase = PH_SP1;
                    else begin fp_phase = PH_SP1; taken = 1'b0; end
                end
                PH_SU: begin
                    fp_phase = PH_SP1;
                    if (b != "I") taken = 1'b0;
                end
                PH_C: begin
                    fp_phase = (b == "1" || b == "U") ? PH_C2 : PH_DONE;
                end
                PH_C2: begin
                    fp_phase = PH_SP1;
                    if (b != "1") taken = 1'b0;
                end
                PH_SP1: begin
                    fp_phase = PH_STAB;
                    if (b != " ") taken = 1'b0;
                end
                PH_STAB: begin
                    fp_phase = PH_SP2;
                    if (b == "?" || b == "^" || b == "v") fp_stable = 1'b0;
                    else if (b == " ") fp_stable = 1'b1;
                    else taken = 1'b0;
                end
                PH_SP2: begin
                    fp_phase = PH_SIGN;
                    if (b != " ") taken = 1'b0;
                end
                PH_SIGN: begin
                    fp_phase = PH_WS;
                    if (b == "-") fp_neg = 1'b1;
                    else if (b != "+" && b != " ") taken = 1'b0;
                end
                PH_WS: begin
                    if (!blank_char(b)) begin fp_phase = PH_NUM; taken = 1'b0; end
                end
                PH_NUM: begin
                    if (numeral(b)) take_digit(b);
                    else if (b == "." || b == ",") begin
                        if (fp_point) fp_err = ST_TWO_POINT;
                        else fp_point = 1'b1;
                    end else if (fp_digits == 0) fp_phase = PH_DONE;
                    else if (b == "[") fp_phase = PH_BR1;
                    else begin fp_phase = PH_WS2; taken = 1'b0; end
                end
                PH_BR1: begin
                    fp_phase = PH_BR2;
                    if (numeral(b)) take_digit(b);
                    else taken = 1'b0;
                end
                PH_BR2: begin
                    fp_phase = PH_WS2;
                    if (b != "]") taken = 1'b0;
                end
                PH_WS2: begin
                    if (!blank_char(b)) begin fp_phase = PH_UNIT; taken = 1'b0; end
                end
                PH_UNIT: begin
                    if (((b >= "a" && b <= "z") || (b >= "A" && b <= "Z"))
                            && fp_letters_n < MAX_UNIT_LETTERS_DEF && fp_letters_n < 3) begin
                        fp_letter[fp_letters_n] = b | CASE_BIT;
                        fp_letters_n++;
                    end else begin
                        fp_phase = PH_DONE;
                    end
                end
                default: fp_phase = PH_DONE;
            endcase
        end
        if (!taken) fp_phase = PH_DONE;
    endfunction

    function automatic t_out_item close_frame();
        t_out_item res;
        res = '0;
        res.status = (fp_digits == 0) ? ST_NO_DIGITS : fp_err;
        res.stable = fp_stable;
        if (res.status == ST_OK) begin
            res.negative        = fp_neg;
            res.mantissa        = fp_value;
            res.fraction_digits = 4'(fp_frac > 15 ? 15 : fp_frac);
            res.unit_code       = UNIT_NONE;
            if (fp_letters_n == 1 && fp_letter[0] == "g") begin
                res.unit_code = UNIT_G;
            end else if (fp_letters_n == 2) begin
                case ({fp_letter[0], fp_letter[1]})
                    "kg":    res.unit_code = UNIT_KG;
                    "ct":    res.unit_code = UNIT_CT;
                    "lb":    res.unit_code = UNIT_LB;
                    "oz":    res.unit_code = UNIT_OZ;
                    default: res.unit_code = UNIT_NONE;
                endcase
            end
        end
        clear_parse();
        return res;
    endfunction

    function automatic t_out_item make_weight(input t_status s, input bit neg,
                                              input longint man, input int frac,
                                              input bit stb, input t_unit u);
        t_out_item w;
        w.status          = s;
        w.negative        = neg;
        w.mantissa        = MANT_W'(man);
        w.fraction_digits = 4'(frac);
        w.stable          = stb;
        w.unit_code       = u;
        return w;
    endfunction

    function automatic void add_row(input string txt, input bit typed, input t_out_item res);
        row_text.push_back(txt);
        row_typed.push_back(typed);
        row_result.push_back(res);
    endfunction

    function automatic int idle_len(input bit enabled);
        int r;
        if (!enabled) return 0;
        r = $urandom_range(0, 99);
        if (r < 65) return 0;
        if (r < 94) return $urandom_range(1, 3);
        return $urandom_range(6, 25);
    endfunction

    function automatic void push_text(ref logic [7:0] q[$], input string s);
        for (int i = 0; i < s.len(); i++) q.push_back(s[i]);
    endfunction

    task automatic check_weight(input t_out_item got);
        t_out_item want;
        if (pending_weights.size() == 0) begin
            bad_results++;
            if (bad_results <= 10)
                $display("unexpected result: st=%0d neg=%0d man=%0d frac=%0d stb=%0d unit=%0d",
                         got.status, got.negative, got.mantissa, got.fraction_digits,
                         got.stable, got.unit_code);
        end else begin
            want = pending_weights.pop_front();
            if (got.status !== want.status || got.negative !== want.negative
                    || got.mantissa !== want.mantissa
                    || got.fraction_digits !== want.fraction_digits
                    || got.stable !== want.stable || got.unit_code !== want.unit_code) begin
                bad_results++;
                if (bad_results <= 10)
                    $display("mismatch: expected st=%0d neg=%0d man=%0d frac=%0d stb=%0d unit=%0d, %s",
                             want.status, want.negative, want.mantissa, want.fraction_digits,
                             want.stable, want.unit_code,
                             $sformatf("got st=%0d neg=%0d man=%0d frac=%0d stb=%0d unit=%0d",
                                       got.status, got.negative, got.mantissa,
                                       got.fraction_digits, got.stable, got.unit_code));
            end
        end
    endtask

    task automatic push_byte(input logic [7:0] b, input logic last, input bit typed,
                             input t_out_item typed_res);
        t_out_item guess;
        int gap;
        in_valid <= 1'b1;
        in_item  <= '{frame_byte: b, last_byte: last};
        do @(posedge i_clk); while (in_stall !== 1'b0);
        scan_byte(b);
        if (last) begin
            guess = close_frame();
            pending_weights.push_back(typed ? typed_res : guess);
        end
        gap = idle_len(send_idle);
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic settle();
        in_valid <= 1'b0;
        do @(posedge i_clk); while (pending_weights.size() != 0);
    endtask

    task automatic gen_frame(inout int n_bytes);
        logic [7:0] fb[$];
        string      pre;
        int         ndig;
        int         pt;
        int         pt2;
        int         r;
        int         unit_at;
        r = $urandom_range(0, 99);
        if (r < 12) begin
            repeat ($urandom_range(1, 6)) fb.push_back(8'($urandom_range(0, 255)));
        end else begin
            case ($urandom_range(0, 10))
                0: pre = "";
                1: pre = "S";
                2: pre = "SI";
                3: pre = "SU";
                4: pre = "SUI";
                5: pre = "C1";
                6: pre = "CU";
                7: pre = "CU1";
                8: pre = "C11";
                9: pre = "C";
                default: pre = "CX";
            endcase
            push_text(fb, pre);
            if ($urandom_range(0, 1)) fb.push_back(CH_SPACE);
            case ($urandom_range(0, 4))
                0: fb.push_back(CH_QUEST);
                1: fb.push_back(CH_CARET);
                2: fb.push_back(CH_LOW_V);
                3: fb.push_back(CH_SPACE);
                default: ;
            endcase
            if ($urandom_range(0, 1)) fb.push_back(CH_SPACE);
            case ($urandom_range(0, 4))
                0: fb.push_back(CH_MINUS);
                1: fb.push_back(CH_PLUS);
                2: fb.push_back(CH_SPACE);
                default: ;
            endcase
            repeat ($urandom_range(0, 2)) fb.push_back($urandom_range(0, 1) ? CH_SPACE : CH_TAB);
            r = $urandom_range(0, 99);
            ndig = (r < 6) ? 0 : (r < 14) ? $urandom_range(12, 14) : $urandom_range(1, 8);
            pt = -1;
            pt2 = -1;
            r = $urandom_range(0, 99);
            if (r < 60) begin
                pt = $urandom_range(0, ndig);
            end else if (r < 68) begin
                pt = $urandom_range(0, ndig);
                pt2 = $urandom_range(pt, ndig);
            end
            for (int i = 0; i <= ndig; i++) begin
                if (i == pt) fb.push_back($urandom_range(0, 1) ? CH_POINT : CH_COMMA);
                if (i == pt2) fb.push_back($urandom_range(0, 1) ? CH_POINT : CH_COMMA);
                if (i < ndig) fb.push_back(8'(CH_ZERO + $urandom_range(0, 9)));
            end
            if ($urandom_range(0, 3) == 0) begin
                fb.push_back(CH_LBR);
                if ($urandom_range(0, 9) < 7) fb.push_back(8'(CH_ZERO + $urandom_range(0, 9)));
                if ($urandom_range(0, 9) < 7) fb.push_back(CH_RBR);
            end
            repeat ($urandom_range(0, 2)) fb.push_back($urandom_range(0, 1) ? CH_SPACE : CH_TAB);
            unit_at = fb.size();
            case ($urandom_range(0, 7))
                0: push_text(fb, "g");
                1: push_text(fb, "kg");
                2: push_text(fb, "ct");
                3: push_text(fb, "lb");
                4: push_text(fb, "oz");
                5: ;
                default: repeat ($urandom_range(1, 4)) fb.push_back(8'(8'h61 + $urandom_range(0, 25)));
            endcase
            for (int i = unit_at; i < fb.size(); i++)
                if ($urandom_range(0, 1)) fb[i] = fb[i] ^ CASE_BIT;
            if ($urandom_range(0, 99) < 15)
                repeat ($urandom_range(1, 3)) fb.push_back(8'($urandom_range(0, 255)));
            if (fb.size() > 0 && $urandom_range(0, 99) < 8)
                fb[$urandom_range(0, fb.size() - 1)] = 8'($urandom_range(0, 255));
        end
        if (fb.size() == 0) fb.push_back(8'($urandom_range(0, 255)));
        for (int i = 0; i < fb.size(); i++) push_byte(fb[i], i == fb.size() - 1, 1'b0, '0);
        n_bytes += fb.size();
    endtask

    initial begin
        int n_bytes;
        int n_frames;
        n_bytes = 0;
        n_frames = 0;
        clear_parse();
        add_row("S  12.345 kg", 1'b1, make_weight(ST_OK, 0, 12345, 3, 1, UNIT_KG));
        add_row("SUI ?-0.5[7]g", 1'b1, make_weight(ST_OK, 1, 57, 2, 0, UNIT_G));
        add_row("CU1 ^+7,25OZ", 1'b1, make_weight(ST_OK, 0, 725, 2, 0, UNIT_OZ));
        add_row("SI v  3 CT", 1'b1, make_weight(ST_OK, 0, 3, 0, 0, UNIT_CT));
        add_row("999999999999lb", 1'b1,
                make_weight(ST_OK, 0, 64'd999999999999, 0, 1, UNIT_LB));
        add_row("C1 0.000 kgx", 1'b1, make_weight(ST_OK, 0, 0, 3, 1, UNIT_NONE));
        add_row("C", 1'b1, make_weight(ST_NO_DIGITS, 0, 0, 0, 1, UNIT_NONE));
        add_row("CX 5 g", 1'b1, make_weight(ST_NO_DIGITS, 0, 0, 0, 1, UNIT_NONE));
        add_row("? kg", 1'b1, make_weight(ST_NO_DIGITS, 0, 0, 0, 0, UNIT_NONE));
        add_row("-1.2.3g", 1'b1, make_weight(ST_TWO_POINT, 0, 0, 0, 1, UNIT_NONE));
        add_row("1234567890123 g", 1'b1, make_weight(ST_TOO_MANY, 0, 0, 0, 1, UNIT_NONE));
        add_row("1234567890123.4.5", 1'b1, make_weight(ST_TWO_POINT, 0, 0, 0, 1, UNIT_NONE));
        add_row("\377", 1'b1, make_weight(ST_NO_DIGITS, 0, 0, 0, 1, UNIT_NONE));
        add_row("SU\t+ \t42[]oz", 1'b0, '0);
        add_row("C11 8[ lb", 1'b0, '0);
        add_row("7 abcd", 1'b0, '0);
        add_row("  3.1[9 Kg", 1'b0, '0);
        add_row("+.5\377G", 1'b0, '0);
        add_row("4 k", 1'b0, '0);

        repeat (9) @(posedge i_clk);
        rst_n <= 1'b1;

        for (int i = 0; i < row_text.size(); i++) begin
            send_idle = ($urandom_range(0, 2) != 0);
            recv_idle = ($urandom_range(0, 2) != 0);
            for (int j = 0; j < row_text[i].len(); j++)
                push_byte(row_text[i][j], j == row_text[i].len() - 1, row_typed[i],
                          row_result[i]);
            n_bytes += row_text[i].len();
        end
        push_byte(8'h00, 1'b1, 1'b1, make_weight(ST_NO_DIGITS, 0, 0, 0, 1, UNIT_NONE));
        n_bytes++;
        settle();

        while (n_bytes < BYTE_BUDGET) begin
            send_idle = ($urandom_range(0, 3) != 0);
            recv_idle = ($urandom_range(0, 3) != 0);
            if (n_frames == 30 || n_frames == 110) hold_requests++;
            if (n_frames == 70) settle();
            gen_frame(n_bytes);
            n_frames++;
        end

        settle();
        repeat (10) @(posedge i_clk);
        if (bad_results == 0 && pending_weights.size() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

    // The output side stalls at random and, on request, holds off for a long stretch.
    initial begin
        int stall_left;
        int hold_left;
        int seen_holds;
        int n;
        stall_left = 0;
        hold_left = 0;
        seen_holds = 0;
        forever begin
            @(posedge i_clk);
            if (rst_n && out_valid === 1'b1 && !out_stall) check_weight(out_item);
            if (seen_holds != hold_requests) begin
                seen_holds = hold_requests;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                out_stall <= 1'b1;
            end else if (stall_left > 0) begin
                stall_left--;
                out_stall <= 1'b1;
            end else begin
                n = idle_len(recv_idle);
                out_stall <= (n > 0);
                if (n > 0) stall_left = n - 1;
            end
        end
    end

    initial begin
        int quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT) begin
            @(posedge i_clk);
            if (rst_n && ((in_valid && in_stall === 1'b0) || (out_valid === 1'b1 && !out_stall)))
                quiet = 0;
            else
                quiet++;
        end
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule
